/* rtl/hgtc_pkg.sv */
// Shared types and constants for the hex grid toolpath cell.
// No dependencies; imported by every module of the block.
package hgtc_pkg;

  // sqrt(3) in Q1.30
  localparam logic [30:0] SQRT3_Q30  = 31'd1859775393;
  localparam logic [3:0]  MAX_NESTED = 4'd8;

  // configuration register indexes
  localparam logic [2:0] REG_SIDE    = 3'd0;
  localparam logic [2:0] REG_NEST    = 3'd1;
  localparam logic [2:0] REG_SPACING = 3'd2;
  localparam logic [2:0] REG_COLS    = 3'd3;
  localparam logic [2:0] REG_GRID    = 3'd4;

  // outer hexagon side skip masks, bit k = step k
  localparam logic [5:0] SKIP_NONE = 6'h00;
  localparam logic [5:0] SKIP_5    = 6'h20;
  localparam logic [5:0] SKIP_0    = 6'h01;
  localparam logic [5:0] SKIP_015  = 6'h23;
  localparam logic [5:0] SKIP_05   = 6'h21;
  localparam logic [5:0] SKIP_1    = 6'h02;

  // vertex slots: start point, then six corners
  localparam logic [2:0] VTX_START = 3'd0;
  localparam logic [2:0] VTX_1     = 3'd1;
  localparam logic [2:0] VTX_2     = 3'd2;
  localparam logic [2:0] VTX_3     = 3'd3;
  localparam logic [2:0] VTX_4     = 3'd4;
  localparam logic [2:0] VTX_5     = 3'd5;
  localparam logic [2:0] VTX_LAST  = 3'd6;

  typedef struct packed {
    logic [10:0] row;
    logic [9:0]  col;
  } in_beat_t;

  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic               pen_down;
    logic               new_shape;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [23:0] side;
    logic [3:0]  nest;
    logic [15:0] spacing;
    logic [10:0] cols;
    logic        grid;
  } cfg_t;

  // per-cell values handed to the shape sequencer
  typedef struct packed {
    logic [34:0] x0;
    logic [35:0] y0;
    logic [5:0]  skip;
  } cell_t;

  // one point request into the point pipeline
  typedef struct packed {
    logic [19:0] si;    // spacing * nest index
    logic [2:0]  vtx;
    logic [5:0]  skip;
    logic        last;
    logic [34:0] x0;
    logic [35:0] y0;
  } tok_t;

  typedef struct packed {
    logic [2:0] vtx;
    logic [5:0] skip;
    logic       last;
  } meta_t;

endpackage

/* rtl/hex_grid_toolpath_cell.sv */
// Hex grid toolpath cell: top level with configuration registers.
// Depends on hgtc_pkg, hgtc_cell_front, hgtc_shape_seq, hgtc_point_pipe.
//
//   channel | signals                           | beat
//   --------+-----------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data       | one grid cell (row, col)
//   out     | out_valid, out_ready, out_data    | one path point
//   cfg     | cfg_valid, cfg_ready, cfg_index,  | one register write
//           | cfg_data                          |
//
// A cell yields 7 points per hexagon, up to 63, one out beat per cycle while
// out_ready is high; the shape sequencer sets the rate. The first point of a
// cell passes through 3 cell stages, the sequencer and 6 point stages. Up to
// three cells queue ahead of the sequencer. Reset is synchronous, clears the
// valid bits and loads the register defaults; cfg is always ready. Out stalls
// back up through the pipeline without losing beats.
module hex_grid_toolpath_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hgtc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hgtc_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import hgtc_pkg::*;

  cfg_t  cfg;
  logic  cell_valid, cell_ready;
  cell_t cell_info;
  logic  tok_valid, tok_ready;
  tok_t  tok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side    <= 24'd65536;
      cfg.nest    <= 4'd1;
      cfg.spacing <= 16'd32768;
      cfg.cols    <= 11'd10;
      cfg.grid    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIDE:    cfg.side    <= cfg_data;
        REG_NEST:    cfg.nest    <= cfg_data[3:0];
        REG_SPACING: cfg.spacing <= cfg_data[15:0];
        REG_COLS:    cfg.cols    <= cfg_data[10:0];
        REG_GRID:    cfg.grid    <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  hgtc_cell_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_info  (cell_info)
  );

  hgtc_shape_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_info  (cell_info),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok)
  );

  hgtc_point_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .side      (cfg.side),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/hgtc_cell_front.sv */
// Three-stage per-cell front end: half-width, cell origin and skip mask.
// Depends on hgtc_pkg.
module hgtc_cell_front (
  input  logic             clk,
  input  logic             rst,
  input  hgtc_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  hgtc_pkg::in_beat_t in_data,
  output logic             cell_valid,
  input  logic             cell_ready,
  output hgtc_pkg::cell_t  cell_info
);
  import hgtc_pkg::*;

  logic        va, vb, vc;
  logic        en_a, en_b, en_c;

  logic [10:0] row_sat;
  logic        even;
  logic [12:0] tri_row;
  logic [10:0] col_p1;
  logic [5:0]  skip_next;

  logic [54:0] a_prod_w;
  logic [36:0] a_prod_y;
  logic [10:0] a_n;
  logic [5:0]  a_skip;

  logic [54:0] w_sum;
  logic [36:0] y_sum;
  logic [23:0] b_w;
  logic [35:0] b_y0;
  logic [10:0] b_n;
  logic [5:0]  b_skip;

  assign en_c     = !vc || cell_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  assign row_sat = (in_data.row == 11'd0) ? 11'd1 : in_data.row;
  assign even    = ~row_sat[0];
  assign tri_row = {1'b0, row_sat, 1'b0} + {2'b00, row_sat} - 13'd2;
  assign col_p1  = {1'b0, in_data.col} + 11'd1;

  always_comb begin
    if (row_sat == 11'd1) begin
      skip_next = (in_data.col == 10'd0) ? SKIP_NONE : SKIP_5;
    end else if (even) begin
      if (in_data.col == 10'd0) skip_next = SKIP_0;
      else if (col_p1 < cfg.cols) skip_next = SKIP_015;  // col < cols - 1
      else skip_next = SKIP_05;
    end else begin
      skip_next = (in_data.col <= 10'd1) ? SKIP_1 : SKIP_015;
    end
  end

  assign w_sum = a_prod_w + (55'd1 << 30);
  assign y_sum = a_prod_y + 37'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_prod_w <= 55'(cfg.side) * 55'(SQRT3_Q30);
      a_prod_y <= 37'(cfg.side) * 37'(tri_row);
      a_n      <= {in_data.col, even};
      a_skip   <= skip_next;
    end
    if (en_b) begin
      b_w    <= w_sum[54:31];
      b_y0   <= y_sum[36:1];
      b_n    <= a_n;
      b_skip <= a_skip;
    end
    if (en_c) begin
      cell_info.x0   <= 35'(b_n) * 35'(b_w);
      cell_info.y0   <= b_y0;
      cell_info.skip <= b_skip;
    end
  end

  assign cell_valid = vc;

endmodule

/* rtl/hgtc_shape_seq.sv */
// Shape and vertex sequencer: walks nested hexagons then the grid hexagon,
// issuing one point request per cycle while tok_ready is high. Depends on hgtc_pkg.
module hgtc_shape_seq (
  input  logic            clk,
  input  logic            rst,
  input  hgtc_pkg::cfg_t  cfg,
  input  logic            cell_valid,
  output logic            cell_ready,
  input  hgtc_pkg::cell_t cell_info,
  output logic            tok_valid,
  input  logic            tok_ready,
  output hgtc_pkg::tok_t  tok
);
  import hgtc_pkg::*;

  logic        busy;
  logic [3:0]  idx;
  logic [19:0] si;
  logic [2:0]  vtx;
  cell_t       cur;

  logic [3:0]  nest_sat;
  logic [3:0]  stop;
  logic        empty;
  logic        last_tok;
  logic        issue;
  logic        load;

  assign nest_sat = (cfg.nest > MAX_NESTED) ? MAX_NESTED : cfg.nest;
  assign stop     = {3'b000, ~cfg.grid};
  assign empty    = (nest_sat == 4'd0) && !cfg.grid;

  assign last_tok   = (idx == stop) && (vtx == VTX_LAST);
  assign issue      = busy && tok_ready;
  assign cell_ready = !busy || (issue && last_tok);
  assign load       = cell_valid && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      vtx  <= VTX_START;
      idx  <= 4'd0;
    end else if (load) begin
      busy <= !empty;   // a cell with nothing to draw is dropped
      idx  <= nest_sat;
      vtx  <= VTX_START;
    end else if (issue) begin
      if (last_tok) begin
        busy <= 1'b0;
      end else if (vtx == VTX_LAST) begin
        vtx <= VTX_START;
        idx <= idx - 4'd1;
      end else begin
        vtx <= vtx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      si  <= 20'(cfg.spacing) * 20'(nest_sat);
      cur <= cell_info;
    end else if (issue && !last_tok && vtx == VTX_LAST) begin
      si <= si - 20'(cfg.spacing);
    end
  end

  assign tok_valid = busy;
  assign tok.si    = si;
  assign tok.vtx   = vtx;
  assign tok.skip  = (idx == 4'd0) ? cur.skip : SKIP_NONE;
  assign tok.last  = last_tok;
  assign tok.x0    = cur.x0;
  assign tok.y0    = cur.y0;

endmodule

/* rtl/hgtc_point_pipe.sv */
// Six-stage point pipeline: inset, shape start, side terms, vertex point.
// The last stage is the output register. Depends on hgtc_pkg.
module hgtc_point_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic [23:0]         side,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  hgtc_pkg::tok_t      tok,
  output logic                out_valid,
  input  logic                out_ready,
  output hgtc_pkg::out_beat_t out_data
);
  import hgtc_pkg::*;

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  // stage 1
  logic [43:0] p1_prod;
  meta_t       p1_m;
  logic [34:0] p1_x0;
  logic [35:0] p1_y0;
  // stage 2
  logic [27:0] p2_h;
  meta_t       p2_m;
  logic [34:0] p2_x0;
  logic [35:0] p2_y0;
  // stage 3
  logic [58:0]        p3_hk;
  logic signed [28:0] p3_s;
  logic [27:0]        p3_ht;
  meta_t              p3_m;
  logic [34:0]        p3_x0;
  logic [35:0]        p3_y0;
  // stage 4
  logic [39:0]        p4_px;
  logic [39:0]        p4_py;
  logic signed [60:0] p4_sk;
  logic signed [28:0] p4_s;
  meta_t              p4_m;
  // stage 5
  logic [39:0]        p5_px;
  logic [39:0]        p5_py;
  logic signed [30:0] p5_l;
  logic signed [28:0] p5_t;
  logic signed [28:0] p5_s;
  meta_t              p5_m;

  logic [43:0]        h_sum;
  logic [28:0]        ht_sum;
  logic [58:0]        hx_sum;
  logic               sk_neg;
  logic [60:0]        sk_abs;
  logic [60:0]        l_sum;
  logic [30:0]        l_mag;
  logic               s_neg;
  logic [28:0]        s_abs;
  logic [28:0]        t_sum;
  logic [28:0]        t_mag;
  logic [39:0]        l40, t40, s40, dx, dy;
  logic [7:0]         skip8;

  assign en6       = !v6 || out_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign tok_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= tok_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // rounding terms, ties away from zero
  assign h_sum  = p1_prod + (44'd1 << 15);
  assign ht_sum = 29'(p2_h) + 29'd1;
  assign hx_sum = p3_hk + (59'd1 << 30);
  assign sk_neg = p4_sk[60];
  assign sk_abs = sk_neg ? 61'(-p4_sk) : 61'(p4_sk);
  assign l_sum  = sk_abs + (61'd1 << 30);
  assign l_mag  = {1'b0, l_sum[60:31]};
  assign s_neg  = p4_s[28];
  assign s_abs  = s_neg ? 29'(-p4_s) : 29'(p4_s);
  assign t_sum  = s_abs + 29'd1;
  assign t_mag  = {1'b0, t_sum[28:1]};

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_prod <= 44'(tok.si) * 44'(side);
      p1_m    <= '{vtx: tok.vtx, skip: tok.skip, last: tok.last};
      p1_x0   <= tok.x0;
      p1_y0   <= tok.y0;
    end
    if (en2) begin
      p2_h  <= h_sum[43:16];
      p2_m  <= p1_m;
      p2_x0 <= p1_x0;
      p2_y0 <= p1_y0;
    end
    if (en3) begin
      p3_hk <= 59'(p2_h) * 59'(SQRT3_Q30);
      p3_s  <= $signed({5'b00000, side}) - $signed({1'b0, p2_h});
      p3_ht <= ht_sum[28:1];
      p3_m  <= p2_m;
      p3_x0 <= p2_x0;
      p3_y0 <= p2_y0;
    end
    if (en4) begin
      p4_px <= 40'(p3_x0) + 40'(hx_sum[58:31]);
      p4_py <= 40'(p3_y0) + 40'(p3_ht);
      p4_sk <= 61'(p3_s) * $signed({30'd0, SQRT3_Q30});
      p4_s  <= p3_s;
      p4_m  <= p3_m;
    end
    if (en5) begin
      p5_px <= p4_px;
      p5_py <= p4_py;
      p5_l  <= sk_neg ? -$signed(l_mag) : $signed(l_mag);
      p5_t  <= s_neg ? -$signed(t_mag) : $signed(t_mag);
      p5_s  <= p4_s;
      p5_m  <= p4_m;
    end
  end

  // vertex offsets from the shape start
  assign l40 = 40'(p5_l);
  assign t40 = 40'(p5_t);
  assign s40 = 40'(p5_s);

  always_comb begin
    case (p5_m.vtx)
      VTX_1:   begin dx = l40;       dy = -t40;      end
      VTX_2:   begin dx = l40 << 1;  dy = 40'd0;     end
      VTX_3:   begin dx = l40 << 1;  dy = s40;       end
      VTX_4:   begin dx = l40;       dy = s40 + t40; end
      VTX_5:   begin dx = 40'd0;     dy = s40;       end
      default: begin dx = 40'd0;     dy = 40'd0;     end
    endcase
  end

  // start slot reads as skipped so its pen stays up
  assign skip8 = {1'b0, p5_m.skip, 1'b1};

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data.x         <= $signed(p5_px + dx);
      out_data.y         <= $signed(p5_py + dy);
      out_data.pen_down  <= !skip8[p5_m.vtx];
      out_data.new_shape <= (p5_m.vtx == VTX_START);
      out_data.last      <= p5_m.last;
    end
  end

  assign out_valid = v6;

endmodule

/* rtl/hgtc_checker.sv */
// Port-level checks for the hex grid toolpath cell, bound to the top level.
// Depends on hgtc_pkg and hex_grid_toolpath_cell.
module hgtc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input hgtc_pkg::out_beat_t out_data,
  input logic                cfg_ready
);
  import hgtc_pkg::*;

  // a stalled out beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat changed while stalled");

  // start point of a shape is always a pen-up move
  a_start_pen_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_shape |-> !out_data.pen_down)
    else $error("pen down on shape start");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out valid right after reset");

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg port not ready");

endmodule

bind hex_grid_toolpath_cell hgtc_checker u_hgtc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

/* dv/hgtc_path_checker.sv */
`timescale 1ns / 1ps
// Path point checker for hex_grid_toolpath_cell: follows register writes,
// predicts each cell's points and compares out beats in order. Needs hgtc_pkg.
module hgtc_path_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hgtc_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hgtc_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output int                  mismatches,
  output int                  points_due
);

  localparam longint ROOT3_Q30 = 64'sd1859775393;
  localparam int     NEST_CAP  = 8;

  logic [23:0] side_q;
  logic [3:0]  nest_q;
  logic [15:0] spacing_q;
  logic [10:0] cols_q;
  logic        grid_q;

  hgtc_pkg::out_beat_t due_q[$];
  hgtc_pkg::out_beat_t cell_pts[0:62];
  int                  cell_len;

  // v / 2^n, nearest, ties away from zero
  function automatic longint round_shr(input longint v, input int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  task automatic add_point(input longint px, input longint py, input logic pen,
                           input logic shape);
    hgtc_pkg::out_beat_t p;
    p.x         = px[39:0];
    p.y         = py[39:0];
    p.pen_down  = pen;
    p.new_shape = shape;
    p.last      = 1'b0;
    cell_pts[cell_len] = p;
    cell_len++;
  endtask

  task automatic trace_hex(input longint px, input longint py, input longint s,
                           input logic [5:0] skip);
    longint run_l;
    longint run_t;
    longint step_x[6];
    longint step_y[6];
    run_l = round_shr(s * ROOT3_Q30, 31);
    run_t = round_shr(s, 1);
    step_x = '{run_l, run_l, 0, -run_l, -run_l, 0};
    step_y = '{-run_t, run_t, s, run_t, -run_t, -s};
    add_point(px, py, 1'b0, 1'b1);
    for (int k = 0; k < 6; k++) begin
      px += step_x[k];
      py += step_y[k];
      add_point(px, py, !skip[k], 1'b0);
    end
  endtask

  task automatic plan_cell(input hgtc_pkg::in_beat_t c);
    longint     row;
    longint     col;
    longint     side;
    longint     sp;
    longint     cnum;
    longint     w;
    longint     x0;
    longint     y0;
    longint     h;
    int         nest;
    logic       even;
    logic [5:0] skip;
    hgtc_pkg::out_beat_t p;
    row  = longint'(c.row);
    col  = longint'(c.col);
    side = longint'(side_q);
    sp   = longint'(spacing_q);
    cnum = longint'(cols_q);
    if (row < 1) row = 1;
    nest = (int'(nest_q) > NEST_CAP) ? NEST_CAP : int'(nest_q);
    even = ~row[0];
    w  = round_shr(side * ROOT3_Q30, 31);
    x0 = (2 * col + (even ? 1 : 0)) * w;
    y0 = round_shr(side * (3 * row - 2), 1);
    cell_len = 0;
    // inner hexagons, highest index first; side may go negative
    for (int i = nest; i > 0; i--) begin
      h = round_shr(sp * i * side, 16);
      trace_hex(x0 + round_shr(h * ROOT3_Q30, 31), y0 + round_shr(h, 1), side - h,
                hgtc_pkg::SKIP_NONE);
    end
    if (grid_q) begin
      if (row == 1) begin
        skip = (col == 0) ? hgtc_pkg::SKIP_NONE : hgtc_pkg::SKIP_5;
      end else if (even) begin
        if (col == 0) skip = hgtc_pkg::SKIP_0;
        else if (col < cnum - 1) skip = hgtc_pkg::SKIP_015;
        else skip = hgtc_pkg::SKIP_05;
      end else begin
        skip = (col <= 1) ? hgtc_pkg::SKIP_1 : hgtc_pkg::SKIP_015;
      end
      trace_hex(x0, y0, side, skip);
    end
    for (int k = 0; k < cell_len; k++) begin
      p = cell_pts[k];
      p.last = (k == cell_len - 1);
      due_q = {due_q, p};
    end
  endtask

  task automatic check_point(input hgtc_pkg::out_beat_t got);
    hgtc_pkg::out_beat_t want;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: point with none due: x=%0d y=%0d pen=%b new=%b last=%b",
                 $realtime, got.x, got.y, got.pen_down, got.new_shape, got.last);
    end else begin
      want = due_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.pen_down !== want.pen_down ||
          got.new_shape !== want.new_shape || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: point differs: want x=%0d y=%0d pen=%b new=%b last=%b",
                   $realtime, want.x, want.y, want.pen_down, want.new_shape, want.last);
          $display("%0t:                  got x=%0d y=%0d pen=%b new=%b last=%b",
                   $realtime, got.x, got.y, got.pen_down, got.new_shape, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      side_q     = 24'd65536;
      nest_q     = 4'd1;
      spacing_q  = 16'd32768;
      cols_q     = 11'd10;
      grid_q     = 1'b1;
      mismatches = 0;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hgtc_pkg::REG_SIDE:    side_q    = cfg_data;
          hgtc_pkg::REG_NEST:    nest_q    = cfg_data[3:0];
          hgtc_pkg::REG_SPACING: spacing_q = cfg_data[15:0];
          hgtc_pkg::REG_COLS:    cols_q    = cfg_data[10:0];
          hgtc_pkg::REG_GRID:    grid_q    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_point(out_data);
      if (in_valid && in_ready) plan_cell(in_data);
    end
    points_due = due_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for hex_grid_toolpath_cell: clock, reset, cell and register
// stimulus, output stalls, watchdog and verdict. Needs hgtc_pkg, the block
// and hgtc_path_checker.
module tb_top;

  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 2000;
  localparam int CELL_TARGET   = 480;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  hgtc_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  hgtc_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = hgtc_pkg::REG_SIDE;
  logic [23:0]         cfg_data  = '0;
  int                  mismatches;
  int                  points_due;

  int stall_left   = 0;
  int steady_left  = 0;
  int steady_cells = 0;
  int ready_roll   = 0;
  int idle_cycles  = 0;

  hex_grid_toolpath_cell dut (.*);
  hgtc_path_checker path_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // out side: short stalls mostly, a few long ones, some stall-free stretches
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (steady_left > 0) begin
        steady_left <= steady_left - 1;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 3) steady_left <= $urandom_range(50, 300);
        else if (ready_roll < 6) stall_left <= $urandom_range(10, 40);
        else if (ready_roll < 35) stall_left <= $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function int sender_gap();
    int r;
    if (steady_cells > 0) begin
      steady_cells--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_cells = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_cell(input logic [10:0] r, input logic [9:0] c);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_data.row <= r;
    in_data.col <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // unused upper data bits carry junk half the time
  task automatic load_config(input hgtc_pkg::cfg_t c);
    logic [23:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? 24'($urandom) : 24'd0;
    write_reg(hgtc_pkg::REG_SIDE, c.side);
    write_reg(hgtc_pkg::REG_NEST, {junk[23:4], c.nest});
    write_reg(hgtc_pkg::REG_SPACING, {junk[23:16], c.spacing});
    write_reg(hgtc_pkg::REG_COLS, {junk[23:11], c.cols});
    write_reg(hgtc_pkg::REG_GRID, {junk[23:1], c.grid});
    cfg_valid <= 1'b0;
  endtask

  // hold cells back until every predicted point is out, then let the
  // pipeline settle with no cells sent
  task automatic drain_path();
    in_valid <= 1'b0;
    while (points_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic hgtc_pkg::cfg_t make_setting(input logic [23:0] side,
      input logic [3:0] nest, input logic [15:0] spacing, input logic [10:0] cols,
      input logic grid);
    hgtc_pkg::cfg_t c;
    c.side    = side;
    c.nest    = nest;
    c.spacing = spacing;
    c.cols    = cols;
    c.grid    = grid;
    return c;
  endfunction

  function automatic hgtc_pkg::cfg_t random_setting();
    hgtc_pkg::cfg_t c;
    int r;
    case ($urandom_range(0, 9))
      0:       c.side = 24'd0;
      1:       c.side = 24'hFFFFFF;
      2, 3:    c.side = 24'($urandom);
      default: c.side = 24'($urandom_range(1, 24'h60000));
    endcase
    r = $urandom_range(0, 19);
    if (r < 2) c.nest = 4'($urandom_range(9, 15));
    else if (r < 4) c.nest = 4'd0;
    else if (r < 6) c.nest = 4'd8;
    else c.nest = 4'($urandom_range(1, 4));
    case ($urandom_range(0, 7))
      0:       c.spacing = 16'd0;
      1:       c.spacing = 16'hFFFF;
      default: c.spacing = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       c.cols = 11'd0;
      1:       c.cols = 11'd2047;
      2:       c.cols = 11'd1024;
      3:       c.cols = 11'd1;
      default: c.cols = 11'($urandom_range(2, 40));
    endcase
    c.grid = ($urandom_range(0, 5) != 0);
    return c;
  endfunction

  // mostly small rows, with columns at the first two, around the grid's last column or random
  function automatic hgtc_pkg::in_beat_t random_cell(input hgtc_pkg::cfg_t c);
    hgtc_pkg::in_beat_t b;
    if ($urandom_range(0, 9) < 2) begin
      b.row = 11'($urandom);
      b.col = 10'($urandom);
    end else begin
      b.row = 11'($urandom_range(0, 12));
      case ($urandom_range(0, 5))
        0:       b.col = 10'd0;
        1:       b.col = 10'd1;
        2:       b.col = 10'(c.cols - 11'd2);
        3:       b.col = 10'(c.cols - 11'd1);
        4:       b.col = 10'(c.cols);
        default: b.col = 10'($urandom_range(0, 40));
      endcase
    end
    return b;
  endfunction

  initial begin
    hgtc_pkg::cfg_t     setting;
    hgtc_pkg::in_beat_t beat;
    int                 sent;
    int                 phase_len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: first row, even rows up to and past the last column,
    // odd rows, row zero, field extremes
    send_cell(11'd1, 10'd0);
    send_cell(11'd1, 10'd5);
    send_cell(11'd2, 10'd0);
    send_cell(11'd2, 10'd5);
    send_cell(11'd2, 10'd9);
    send_cell(11'd2, 10'd10);
    send_cell(11'd3, 10'd0);
    send_cell(11'd3, 10'd1);
    send_cell(11'd3, 10'd2);
    send_cell(11'd0, 10'd3);
    send_cell(11'd2047, 10'd1023);
    send_cell(11'd1024, 10'd1023);
    drain_path();

    // widest side, nest count past the cap, negative inner sides, no columns
    load_config(make_setting(24'hFFFFFF, 4'd15, 16'hFFFF, 11'd0, 1'b1));
    send_cell(11'd2, 10'd1);
    send_cell(11'd2047, 10'd1023);
    send_cell(11'd1, 10'd0);
    drain_path();

    // nothing to draw
    load_config(make_setting(24'h018000, 4'd0, 16'h1234, 11'd5, 1'b0));
    send_cell(11'd5, 10'd5);
    send_cell(11'd0, 10'd0);
    drain_path();

    // grid only, zero side
    load_config(make_setting(24'd0, 4'd0, 16'd0, 11'd1024, 1'b1));
    send_cell(11'd2, 10'd1022);
    send_cell(11'd2, 10'd1023);
    send_cell(11'd4, 10'd0);
    drain_path();

    // full nesting at zero spacing, no grid
    load_config(make_setting(24'h0ABCDE, 4'd8, 16'd0, 11'd1, 1'b0));
    send_cell(11'd7, 10'd3);

    sent = 0;
    while (sent < CELL_TARGET) begin
      drain_path();
      setting = random_setting();
      load_config(setting);
      phase_len = $urandom_range(20, 50);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 49) == 0) drain_path();
        beat = random_cell(setting);
        send_cell(beat.row, beat.col);
        if (setting.nest != 4'd0 || setting.grid) sent++;
      end
    end
    drain_path();

    if (mismatches == 0 && points_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hgtc_pkg.sv
rtl/hgtc_cell_front.sv
rtl/hgtc_shape_seq.sv
rtl/hgtc_point_pipe.sv
rtl/hex_grid_toolpath_cell.sv
rtl/hgtc_checker.sv
dv/hgtc_path_checker.sv
dv/tb_top.sv
